// ===== rtl/tdor_pkg.sv =====
`default_nettype none
package tdor_pkg;
    localparam int MAX_DIMS       = 4;
    localparam int SWITCH_ID_BITS = 24;
    localparam int DIM_SIZE_BITS  = 8;
    localparam int NUM_SIZE_REGS  = 4;
    localparam int PORT_BITS      = 3;
    localparam int NDIMS_BITS     = 3;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 8;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_DIMS  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_DIM0 = 3'd1;

    localparam logic [NDIMS_BITS-1:0]    NUM_DIMS_RESET = 3'd3;
    localparam logic [DIM_SIZE_BITS-1:0] SIZE_RESET_LO  = 8'd4;
    localparam logic [DIM_SIZE_BITS-1:0] SIZE_RESET_HI  = 8'd1;

    typedef struct packed {
        logic [SWITCH_ID_BITS-1:0] source_switch;
        logic [SWITCH_ID_BITS-1:0] dest_switch;
        logic                      dateline_in;
    } t_in;

    typedef struct packed {
        logic [PORT_BITS-1:0] out_port;
        logic                 virtual_channel;
        logic                 dateline_out;
        logic                 arrived;
    } t_out;
endpackage
`default_nettype wire

// ===== rtl/torus_dimension_order_route_top.sv =====
// channel | dir | handshake            | payload
// in      | in  | i_in_valid/o_in_ready | i_in  (tdor_pkg::t_in)
// out     | out | o_out_valid/i_out_ready | o_out (tdor_pkg::t_out)
// cfg     | in  | i_cfg_we              | i_cfg_idx, i_cfg_data
// one transfer per cycle unless the output stalls; 24 divider stages (4 quotient
// bits each, four digits of both ids) then a per-dimension stage and the
// output register. reset (synchronous, active low) clears valid bits and
// loads the default ring sizes. a stall freezes the whole pipeline, so no
// item is lost or repeated.
`default_nettype none
module torus_dimension_order_route_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire tdor_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output tdor_pkg::t_out     o_out,
    input  wire logic          i_cfg_we,
    input  wire logic [tdor_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [tdor_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import tdor_pkg::*;

    localparam int DS    = DIM_SIZE_BITS;
    localparam int IDB   = SWITCH_ID_BITS;
    localparam int BPS   = 4;
    localparam int TOTAL = MAX_DIMS * IDB;
    localparam int NS    = (TOTAL + BPS - 1) / BPS;
    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SR_W  = $clog2(NUM_SIZE_REGS);

    typedef logic [MAX_DIMS-1:0][DS-1:0] t_digits;

    // configuration
    logic [NDIMS_BITS-1:0] r_num_dims;
    logic [DS-1:0]         r_size [NUM_SIZE_REGS];
    logic [DS-1:0]         eff_size [MAX_DIMS];
    logic [MAX_DIMS-1:0]   used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= NUM_DIMS_RESET;
            for (int i = 0; i < NUM_SIZE_REGS; i++)
                r_size[i] <= (i == NUM_SIZE_REGS - 1) ? SIZE_RESET_HI : SIZE_RESET_LO;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_NUM_DIMS) begin
                r_num_dims <= i_cfg_data[NDIMS_BITS-1:0];
            end else if (i_cfg_idx >= REG_SIZE_DIM0 &&
                         {1'b0, i_cfg_idx} <= (CFG_IDX_BITS+1)'(NUM_SIZE_REGS)) begin
                r_size[SR_W'(i_cfg_idx - REG_SIZE_DIM0)] <= i_cfg_data[DS-1:0];
            end
        end
    end

    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            eff_size[d] = DS'(1);
            if (d < NUM_SIZE_REGS && r_size[d] != '0)
                eff_size[d] = r_size[d];
            used[d] = ({1'b0, r_num_dims} > (NDIMS_BITS+1)'(d));
        end
    end

    // global pipeline enable
    logic r_ov;
    logic en;
    assign en          = !r_ov || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_ov;

    // divider pipeline, index 0 is the input side
    logic          p_v  [NS+1];
    logic [IDB-1:0] p_xs [NS+1];
    logic [IDB-1:0] p_xd [NS+1];
    logic [DS-1:0] p_rs [NS+1];
    logic [DS-1:0] p_rd [NS+1];
    t_digits       p_ds [NS+1];
    t_digits       p_dd [NS+1];
    logic          p_b  [NS+1];

    assign p_v[0]  = i_in_valid;
    assign p_xs[0] = i_in.source_switch;
    assign p_xd[0] = i_in.dest_switch;
    assign p_rs[0] = '0;
    assign p_rd[0] = '0;
    assign p_ds[0] = '0;
    assign p_dd[0] = '0;
    assign p_b[0]  = i_in.dateline_in;

    for (genvar k = 0; k < NS; k++) begin : g_div
        logic           r_v;
        logic [IDB-1:0] r_xs, r_xd, n_xs, n_xd;
        logic [DS-1:0]  r_rs, r_rd, n_rs, n_rd;
        t_digits        r_ds, r_dd, n_ds, n_dd;
        logic           r_b;

        always_comb begin
            int           s;
            int           d;
            logic [DS:0]  sh;
            logic [DS-1:0] sz;
            n_xs = p_xs[k];
            n_xd = p_xd[k];
            n_rs = p_rs[k];
            n_rd = p_rd[k];
            n_ds = p_ds[k];
            n_dd = p_dd[k];
            for (int j = 0; j < BPS; j++) begin
                s = k * BPS + j;
                if (s < TOTAL) begin
                    d = s / IDB;
                    if (s % IDB == 0 && s != 0) begin
                        // previous digit done: remainder is its coordinate
                        n_ds[DIM_W'(d-1)] = n_rs;
                        n_dd[DIM_W'(d-1)] = n_rd;
                        n_rs = '0;
                        n_rd = '0;
                    end
                    sz = eff_size[DIM_W'(d)];
                    sh = {n_rs, n_xs[IDB-1]};
                    if (sh >= {1'b0, sz}) begin
                        sh = sh - {1'b0, sz};
                        n_xs = {n_xs[IDB-2:0], 1'b1};
                    end else begin
                        n_xs = {n_xs[IDB-2:0], 1'b0};
                    end
                    n_rs = sh[DS-1:0];
                    sh = {n_rd, n_xd[IDB-1]};
                    if (sh >= {1'b0, sz}) begin
                        sh = sh - {1'b0, sz};
                        n_xd = {n_xd[IDB-2:0], 1'b1};
                    end else begin
                        n_xd = {n_xd[IDB-2:0], 1'b0};
                    end
                    n_rd = sh[DS-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (en) begin
                r_v <= p_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_xs <= n_xs;
                r_xd <= n_xd;
                r_rs <= n_rs;
                r_rd <= n_rd;
                r_ds <= n_ds;
                r_dd <= n_dd;
                r_b  <= p_b[k];
            end
        end

        assign p_v[k+1]  = r_v;
        assign p_xs[k+1] = r_xs;
        assign p_xd[k+1] = r_xd;
        assign p_rs[k+1] = r_rs;
        assign p_rd[k+1] = r_rd;
        assign p_ds[k+1] = r_ds;
        assign p_dd[k+1] = r_dd;
        assign p_b[k+1]  = r_b;
    end

    // per-dimension ring decision
    t_digits             fin_s, fin_d;
    logic [MAX_DIMS-1:0] n_diff, n_up, n_reach, n_wrap;
    logic [MAX_DIMS-1:0] r_diff, r_up, r_reach, r_wrap;
    logic                r_av, r_ab;

    always_comb begin
        logic [DS:0]   up, down, sx, dx, sz, sx1, dx1;
        fin_s = p_ds[NS];
        fin_d = p_dd[NS];
        fin_s[MAX_DIMS-1] = p_rs[NS];
        fin_d[MAX_DIMS-1] = p_rd[NS];
        for (int d = 0; d < MAX_DIMS; d++) begin
            sx = {1'b0, fin_s[d]};
            dx = {1'b0, fin_d[d]};
            sz = {1'b0, eff_size[d]};
            if (dx > sx) begin
                up   = dx - sx;
                down = sx + sz - dx;
            end else begin
                up   = dx + sz - sx;
                down = sx - dx;
            end
            sx1 = (sx + 1'b1 == sz) ? '0 : sx + 1'b1;
            dx1 = (dx + 1'b1 == sz) ? '0 : dx + 1'b1;
            n_diff[d] = used[d] && (sx != dx);
            n_up[d]   = up <= down;
            if (up <= down) begin
                n_reach[d] = sx1 == dx;
                n_wrap[d]  = sx == sz - 1'b1;
            end else begin
                n_reach[d] = sx == dx1;
                n_wrap[d]  = sx == '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (en) begin
            r_av <= p_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_diff  <= n_diff;
            r_up    <= n_up;
            r_reach <= n_reach;
            r_wrap  <= n_wrap;
            r_ab    <= p_b[NS];
        end
    end

    // lowest differing dimension wins
    t_out n_out, r_out;
    always_comb begin
        logic hit;
        logic bit_v;
        hit   = 1'b0;
        bit_v = 1'b0;
        n_out = '0;
        n_out.arrived      = 1'b1;
        n_out.dateline_out = r_ab;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (!hit && r_diff[d]) begin
                hit   = 1'b1;
                bit_v = r_ab | r_wrap[d];
                n_out.out_port        = PORT_BITS'(2 * d) | {{(PORT_BITS-1){1'b0}}, !r_up[d]};
                n_out.virtual_channel = bit_v;
                n_out.dateline_out    = bit_v & !r_reach[d];
                n_out.arrived         = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;
endmodule
`default_nettype wire

// ===== tb/sv/tb_torus_dimension_order_route_top.sv =====
`default_nettype none
module tb_torus_dimension_order_route_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tdor_pkg::*;

    localparam int LATENCY = 26;
    localparam int STALL_LIMIT = 2000;

    // route calculator plus queue of expected routes
    class route_scoreboard;
        logic [NDIMS_BITS-1:0]    dims;
        logic [DIM_SIZE_BITS-1:0] ring [NUM_SIZE_REGS];
        t_out                     pending [$];
        int                       errors;

        function new();
            dims = NUM_DIMS_RESET;
            ring[0] = SIZE_RESET_LO;
            ring[1] = SIZE_RESET_LO;
            ring[2] = SIZE_RESET_LO;
            ring[3] = SIZE_RESET_HI;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            if (idx == REG_NUM_DIMS) begin
                dims = val[NDIMS_BITS-1:0];
            end else if (idx >= REG_SIZE_DIM0 && idx < REG_SIZE_DIM0 + NUM_SIZE_REGS) begin
                ring[idx - REG_SIZE_DIM0] = val;
            end
        endfunction

        function void note_packet(t_in pkt);
            t_out r;
            longint unsigned radix, sz, sx, dx, up, down;
            int nd;
            logic bitv, go_up, wrapped, reached, found;
            r = '0;
            bitv = pkt.dateline_in;
            nd = (dims > MAX_DIMS) ? MAX_DIMS : dims;
            radix = 1;
            found = 1'b0;
            for (int d = 0; d < nd && !found; d++) begin
                sz = (d < NUM_SIZE_REGS) ? ring[d] : 1;
                if (sz == 0) sz = 1;
                sx = (longint'(pkt.source_switch) / radix) % sz;
                dx = (longint'(pkt.dest_switch) / radix) % sz;
                if (sx != dx) begin
                    if (dx > sx) begin
                        up = dx - sx;
                        down = sx + sz - dx;
                    end else begin
                        up = dx + sz - sx;
                        down = sx - dx;
                    end
                    go_up = (up <= down);
                    if (go_up) begin
                        reached = ((sx + 1) % sz) == dx;
                        wrapped = (sx == sz - 1);
                    end else begin
                        reached = (sx == (dx + 1) % sz);
                        wrapped = (sx == 0);
                    end
                    if (wrapped) bitv = 1'b1;
                    r.out_port = PORT_BITS'(2 * d + (go_up ? 0 : 1));
                    r.virtual_channel = bitv;
                    if (reached) bitv = 1'b0;
                    r.dateline_out = bitv;
                    r.arrived = 1'b0;
                    found = 1'b1;
                end
                radix = radix * sz;
                if (radix > (64'd1 << SWITCH_ID_BITS)) radix = 64'd1 << SWITCH_ID_BITS;
            end
            if (!found) begin
                r.dateline_out = bitv;
                r.arrived = 1'b1;
            end
            pending.push_back(r);
        endfunction

        function void check_route(t_out got);
            t_out w;
            if (pending.size() == 0) begin
                $error("unexpected route %h", got);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.out_port !== w.out_port) begin
                $error("out_port exp %0d got %0d", w.out_port, got.out_port);
                errors++;
            end
            if (got.virtual_channel !== w.virtual_channel) begin
                $error("virtual_channel exp %0d got %0d", w.virtual_channel, got.virtual_channel);
                errors++;
            end
            if (got.dateline_out !== w.dateline_out) begin
                $error("dateline_out exp %0d got %0d", w.dateline_out, got.dateline_out);
                errors++;
            end
            if (got.arrived !== w.arrived) begin
                $error("arrived exp %0d got %0d", w.arrived, got.arrived);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    route_scoreboard sb = new();
    int idle_cycles = 0;
    bit sending_done = 0;

    always #5 i_clk = ~i_clk;

    torus_dimension_order_route_top dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_packet(i_in);
            if (o_out_valid && i_out_ready) sb.check_route(o_out);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (sending_done && sb.pending.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("torus_dimension_order_route_top test failed");
                $finish;
            end
        end
    end

    // receiver with random back-pressure
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            w = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w != 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // valid stays high between back-to-back transfers; drain drops it
    task automatic send_packet(t_in pkt, bit fast);
        int w;
        w = fast ? 0 : $urandom_range(0, 8);
        if (w != 0) begin
            i_in_valid <= 1'b0;
            repeat (w) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= pkt;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    function automatic t_in make_pkt(logic [23:0] s, logic [23:0] d, logic b);
        t_in p;
        p.source_switch = s;
        p.dest_switch = d;
        p.dateline_in = b;
        return p;
    endfunction

    // id made of valid digits for the current setting
    function automatic logic [23:0] torus_id();
        longint unsigned id, radix, sz;
        id = 0;
        radix = 1;
        for (int d = 0; d < NUM_SIZE_REGS; d++) begin
            sz = sb.ring[d] == 0 ? 1 : sb.ring[d];
            id += radix * $urandom_range(0, int'(sz) - 1);
            radix *= sz;
            if (radix >= (64'd1 << 24)) break;
        end
        return id[23:0];
    endfunction

    initial begin
        logic [23:0] s, d;
        int sel;
        bit fast;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset sizes, arrival, wraps, ties, extremes
        send_packet(make_pkt(24'd5, 24'd5, 1'b1), 0);
        send_packet(make_pkt(24'd0, 24'd3, 1'b0), 0);
        send_packet(make_pkt(24'd3, 24'd0, 1'b0), 0);
        send_packet(make_pkt(24'd0, 24'd2, 1'b1), 0);
        send_packet(make_pkt(24'd0, 24'd1, 1'b1), 0);
        send_packet(make_pkt(24'd0, 24'd16, 1'b0), 0);
        send_packet(make_pkt(24'd0, 24'd48, 1'b1), 0);
        send_packet(make_pkt(24'hFFFFFF, 24'd0, 1'b0), 0);
        send_packet(make_pkt(24'd0, 24'hFFFFFF, 1'b1), 0);
        send_packet(make_pkt(24'd64, 24'd0, 1'b0), 0);
        drain();
        write_reg(REG_NUM_DIMS, 8'd0);
        send_packet(make_pkt(24'd1, 24'd2, 1'b1), 0);
        drain();
        write_reg(REG_NUM_DIMS, 8'd7);
        write_reg(REG_SIZE_DIM0, 8'd0);
        write_reg(CFG_IDX_BITS'(REG_SIZE_DIM0 + 1), 8'd255);
        write_reg(CFG_IDX_BITS'(REG_SIZE_DIM0 + 2), 8'd255);
        write_reg(CFG_IDX_BITS'(REG_SIZE_DIM0 + 3), 8'd255);
        write_reg(3'd5, 8'hFF);
        write_reg(3'd7, 8'hAA);
        send_packet(make_pkt(24'd0, 24'hFFFFFF, 1'b0), 0);
        send_packet(make_pkt(24'hFFFFFF, 24'd0, 1'b1), 0);
        send_packet(make_pkt(24'd254, 24'd0, 1'b0), 0);
        send_packet(make_pkt(24'd0, 24'd254, 1'b0), 0);
        send_packet(make_pkt(24'd0, 24'd127, 1'b1), 0);
        send_packet(make_pkt(24'd0, 24'd128, 1'b1), 0);
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            write_reg(REG_NUM_DIMS, phase < 2 ? 8'(phase + 3) : 8'($urandom_range(0, 7)));
            for (int k = 0; k < NUM_SIZE_REGS; k++) begin
                sel = $urandom_range(0, 5);
                write_reg(CFG_IDX_BITS'(REG_SIZE_DIM0 + k),
                          sel == 0 ? 8'd255 : sel == 1 ? 8'd1 :
                          sel == 2 ? 8'd0 : sel == 3 ? 8'd2 : 8'($urandom_range(1, 255)));
            end
            fast = (phase % 3 == 2);
            for (int n = 0; n < 125; n++) begin
                sel = $urandom_range(0, 9);
                if (sel < 6) begin
                    s = torus_id();
                    d = torus_id();
                end else if (sel == 6) begin
                    s = torus_id();
                    d = s;
                end else begin
                    s = 24'($urandom());
                    d = 24'($urandom());
                end
                send_packet(make_pkt(s, d, 1'($urandom_range(0, 1))), fast);
            end
            drain();
        end

        sending_done = 1;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("torus_dimension_order_route_top test passed");
        else
            $display("torus_dimension_order_route_top test failed");
        $finish;
    end
endmodule
`default_nettype wire
